@@ hw/rtl/mhd_pkg.sv @@
// shared types, constants and codes of the modified hikkake detector
package mhd_pkg;

    // default parameter values
    localparam int DEF_MAX_PERIOD = 16;
    localparam int DEF_PRICE_BITS = 32;

    // fixed field and register widths
    localparam int FIELD_W    = 32;
    localparam int IN_DATA_W  = 4 * FIELD_W;
    localparam int CODE_W     = 9;
    localparam int OUT_DATA_W = 16;
    localparam int PERIOD_W   = 5;
    localparam int FACTOR_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CD_W       = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MODE  = 2'd2;

    // configuration reset values
    localparam logic [PERIOD_W-1:0] RST_NEAR_PERIOD = 5'd5;
    localparam logic [FACTOR_W-1:0] RST_NEAR_FACTOR = 11'd51;
    localparam logic                RST_RANGE_MODE  = 1'b0;

    // range mode codes
    localparam logic MODE_HIGH_LOW   = 1'b0;
    localparam logic MODE_CLOSE_OPEN = 1'b1;

    // algorithm constants
    localparam int FRAC_SHIFT     = 8;
    localparam int WARMUP_EXTRA   = 5;
    localparam int CONFIRM_WINDOW = 4;

    // result codes
    localparam logic signed [CODE_W-1:0] CODE_NONE       = 9'sd0;
    localparam logic signed [CODE_W-1:0] CODE_BULL_SETUP = 9'sd100;
    localparam logic signed [CODE_W-1:0] CODE_BEAR_SETUP = -9'sd100;
    localparam logic signed [CODE_W-1:0] CODE_BULL_CONF  = 9'sd200;
    localparam logic signed [CODE_W-1:0] CODE_BEAR_CONF  = -9'sd200;

    // direction of the pending setup
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_BULL = 2'd1,
        DIR_BEAR = 2'd2
    } t_dir;

endpackage

@@ hw/rtl/mhd_range_sum.sv @@
// sliding sums of the last 1..MAX_PERIOD candle ranges, one running sum per window length
module mhd_range_sum
    import mhd_pkg::*;
#(
    parameter int MAX_PERIOD = DEF_MAX_PERIOD,
    parameter int PRICE_BITS = DEF_PRICE_BITS,
    parameter int P_W        = $clog2(MAX_PERIOD + 1),
    parameter int SUM_W      = PRICE_BITS + P_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  logic [PRICE_BITS-1:0] i_range,
    input  logic [P_W-1:0]        i_period,
    output logic [SUM_W-1:0]      o_sum
);

    localparam int IDX_W = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;

    logic [PRICE_BITS-1:0] r_ring [MAX_PERIOD];
    logic [SUM_W-1:0]      r_sum  [MAX_PERIOD];
    logic [IDX_W-1:0]      w_idx;

    // ring as a shift line: entry 0 is the newest range, sum k covers entries 0..k
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PERIOD; k++) begin
                r_ring[k] <= '0;
                r_sum[k]  <= '0;
            end
        end else if (i_shift) begin
            r_ring[0] <= i_range;
            for (int k = 1; k < MAX_PERIOD; k++) begin
                r_ring[k] <= r_ring[k-1];
            end
            for (int k = 0; k < MAX_PERIOD; k++) begin
                r_sum[k] <= r_sum[k] + SUM_W'(i_range) - SUM_W'(r_ring[k]);
            end
        end
    end

    // pick the sum of the requested window; a zero period yields zero
    assign w_idx = IDX_W'(i_period - P_W'(1));
    assign o_sum = (i_period == '0) ? '0 : r_sum[w_idx];

endmodule

@@ hw/rtl/mhd_near_test.sv @@
// division-free close-near test: dist * 256 * period <= factor * base
module mhd_near_test
    import mhd_pkg::*;
#(
    parameter int PRICE_BITS = DEF_PRICE_BITS,
    parameter int P_W        = $clog2(DEF_MAX_PERIOD + 1),
    parameter int SUM_W      = PRICE_BITS + P_W
) (
    input  logic [PRICE_BITS-1:0] i_dist,
    input  logic [P_W-1:0]        i_period,
    input  logic [FACTOR_W-1:0]   i_factor,
    input  logic [SUM_W-1:0]      i_base,
    output logic                  o_near
);

    localparam int LHS_W = PRICE_BITS + P_W + FRAC_SHIFT;
    localparam int RHS_W = SUM_W + FACTOR_W;

    logic [LHS_W-1:0] w_lhs;
    logic [RHS_W-1:0] w_rhs;

    // scaled distance against scaled average range
    assign w_lhs  = LHS_W'(i_dist) * LHS_W'({i_period, FRAC_SHIFT'(0)});
    assign w_rhs  = RHS_W'(i_factor) * RHS_W'(i_base);
    assign o_near = (RHS_W'(w_lhs) <= w_rhs);

endmodule

@@ hw/rtl/modified_hikkake_detector.sv @@
// top level of the modified hikkake candlestick detector
//
// channel   direction  tdata (low bit up)                          tuser
// s_axis    in         bar_open, bar_high, bar_low, bar_close      -
// m_axis    out        pattern_code (9b signed), zero pad to 16    result_valid
// cfg       in         write enable, index, 11-bit data            -
//
// one item per cycle while the output is not stalled; an accepted item passes
// through the input register, then the result register
// the per-bar path is one range mux, two narrow multiplies and a compare
// reset is synchronous, loads the configuration reset values and clears history and range sums
// a stalled output holds the result; the input register keeps taking items
// as long as the result register can move
module modified_hikkake_detector
    import mhd_pkg::*;
#(
    parameter int MAX_PERIOD = DEF_MAX_PERIOD,
    parameter int PRICE_BITS = DEF_PRICE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input bars
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // bar_open, bar_high, bar_low, bar_close
    // result codes
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // pattern_code, zero pad
    output logic                  o_m_axis_tuser,   // result_valid
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int P_W   = $clog2(MAX_PERIOD + 1);
    localparam int SUM_W = PRICE_BITS + P_W;
    localparam int CMP_W = (P_W > PERIOD_W) ? P_W : PERIOD_W;
    localparam int CNT_W = $clog2(MAX_PERIOD + WARMUP_EXTRA + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PERIOD + WARMUP_EXTRA);

    // configuration
    logic [PERIOD_W-1:0] r_near_period;
    logic [FACTOR_W-1:0] r_near_factor;
    logic                r_range_mode;

    // input register
    logic                  r_in_valid;
    logic [PRICE_BITS-1:0] r_in_open, r_in_high, r_in_low, r_in_close;

    // bar history: index 0 is the previous bar
    logic [PRICE_BITS-1:0] r_high_h  [3];
    logic [PRICE_BITS-1:0] r_low_h   [3];
    logic [PRICE_BITS-1:0] r_open_h  [2];
    logic [PRICE_BITS-1:0] r_close_h [2];

    // setup tracking
    t_dir                  r_dir;
    logic [CD_W-1:0]       r_countdown;
    logic [PRICE_BITS-1:0] r_third_high, r_third_low;
    logic [CNT_W-1:0]      r_bar_count;

    // result register
    logic                     r_out_valid;
    logic signed [CODE_W-1:0] r_out_code;
    logic                     r_out_flag;

    // combinational signals
    logic                  w_adv, w_proc;
    logic [CMP_W-1:0]      w_per_ext;
    logic [P_W-1:0]        w_p, w_pd;
    logic [PRICE_BITS-1:0] h0, l0, c0, h1, l1, h2, l2, h3, l3, o2, c2;
    logic [PRICE_BITS-1:0] w_r2, w_dist;
    logic [SUM_W-1:0]      w_sum, w_base;
    logic                  w_near, w_inside, w_bull, w_bear, w_setup, w_confirm;
    logic                  w_warm;
    logic signed [CODE_W-1:0] n_code;
    t_dir                  n_dir;
    logic [CD_W-1:0]       n_countdown;

    // handshake: the result register moves when empty or taken
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_proc          = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_period <= RST_NEAR_PERIOD;
            r_near_factor <= RST_NEAR_FACTOR;
            r_range_mode  <= RST_RANGE_MODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NEAR_PERIOD: r_near_period <= i_cfg_wdata[PERIOD_W-1:0];
                REG_NEAR_FACTOR: r_near_factor <= i_cfg_wdata[FACTOR_W-1:0];
                REG_RANGE_MODE:  r_range_mode  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_open  <= PRICE_BITS'(i_s_axis_tdata[0*FIELD_W +: FIELD_W]);
            r_in_high  <= PRICE_BITS'(i_s_axis_tdata[1*FIELD_W +: FIELD_W]);
            r_in_low   <= PRICE_BITS'(i_s_axis_tdata[2*FIELD_W +: FIELD_W]);
            r_in_close <= PRICE_BITS'(i_s_axis_tdata[3*FIELD_W +: FIELD_W]);
        end
    end

    // bar naming: 0 current, 1 previous, 2 the one before, 3 oldest
    assign h0 = r_in_high;
    assign l0 = r_in_low;
    assign c0 = r_in_close;
    assign h1 = r_high_h[0];
    assign l1 = r_low_h[0];
    assign h2 = r_high_h[1];
    assign l2 = r_low_h[1];
    assign h3 = r_high_h[2];
    assign l3 = r_low_h[2];
    assign o2 = r_open_h[1];
    assign c2 = r_close_h[1];

    // effective period, saturated at the ring depth
    assign w_per_ext = CMP_W'(r_near_period);
    assign w_p  = (w_per_ext > CMP_W'(MAX_PERIOD)) ? P_W'(MAX_PERIOD) : P_W'(w_per_ext);
    assign w_pd = (w_p == '0) ? P_W'(1) : w_p;

    // range of the second candle
    always_comb begin
        if (r_range_mode == MODE_CLOSE_OPEN) begin
            w_r2 = (c2 >= o2) ? (c2 - o2) : (o2 - c2);
        end else begin
            w_r2 = (h2 >= l2) ? (h2 - l2) : (l2 - h2);
        end
    end

    mhd_range_sum #(
        .MAX_PERIOD (MAX_PERIOD),
        .PRICE_BITS (PRICE_BITS),
        .P_W        (P_W),
        .SUM_W      (SUM_W)
    ) u_range_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_proc),
        .i_range  (w_r2),
        .i_period (w_p),
        .o_sum    (w_sum)
    );

    assign w_base = (w_p == '0) ? SUM_W'(w_r2) : w_sum;

    // bull and bear exclude each other by the high compare, so one distance serves
    assign w_dist = (h0 < h1) ? (c2 - l2) : (h2 - c2);

    mhd_near_test #(
        .PRICE_BITS (PRICE_BITS),
        .P_W        (P_W),
        .SUM_W      (SUM_W)
    ) u_near_test (
        .i_dist   (w_dist),
        .i_period (w_pd),
        .i_factor (r_near_factor),
        .i_base   (w_base),
        .o_near   (w_near)
    );

    // pattern decision
    assign w_inside  = (h2 < h3) && (l2 > l3) && (h1 < h2) && (l1 > l2);
    assign w_bull    = (h0 < h1) && (l0 < l1) && ((c2 < l2) || w_near);
    assign w_bear    = (h0 > h1) && (l0 > l1) && ((c2 > h2) || w_near);
    assign w_setup   = w_inside && (w_bull || w_bear);
    assign w_confirm = (r_countdown != '0) &&
                       (((r_dir == DIR_BULL) && (c0 > r_third_high)) ||
                        ((r_dir == DIR_BEAR) && (c0 < r_third_low)));
    assign w_warm    = (r_bar_count >= (CNT_W'(w_pd) + CNT_W'(WARMUP_EXTRA)));

    always_comb begin
        n_code      = CODE_NONE;
        n_dir       = r_dir;
        n_countdown = r_countdown;
        priority if (w_setup) begin
            n_dir       = w_bull ? DIR_BULL : DIR_BEAR;
            n_code      = w_bull ? CODE_BULL_SETUP : CODE_BEAR_SETUP;
            n_countdown = CD_W'(CONFIRM_WINDOW - 1);
        end else if (w_confirm) begin
            n_code      = (r_dir == DIR_BULL) ? CODE_BULL_CONF : CODE_BEAR_CONF;
            n_countdown = '0;
        end else if (r_countdown != '0) begin
            n_countdown = r_countdown - CD_W'(1);
        end else begin
            n_countdown = '0;
        end
        if (!w_warm) begin
            n_code = CODE_NONE;
        end
    end

    // state update per processed bar
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_high_h[k] <= '0;
                r_low_h[k]  <= '0;
            end
            for (int k = 0; k < 2; k++) begin
                r_open_h[k]  <= '0;
                r_close_h[k] <= '0;
            end
            r_dir        <= DIR_NONE;
            r_countdown  <= '0;
            r_third_high <= '0;
            r_third_low  <= '0;
            r_bar_count  <= '0;
        end else if (w_proc) begin
            r_high_h[2]  <= h2;
            r_high_h[1]  <= h1;
            r_high_h[0]  <= h0;
            r_low_h[2]   <= l2;
            r_low_h[1]   <= l1;
            r_low_h[0]   <= l0;
            r_open_h[1]  <= r_open_h[0];
            r_open_h[0]  <= r_in_open;
            r_close_h[1] <= r_close_h[0];
            r_close_h[0] <= c0;
            r_dir        <= n_dir;
            r_countdown  <= n_countdown;
            if (w_setup) begin
                r_third_high <= h1;
                r_third_low  <= l1;
            end
            if (r_bar_count < CNT_MAX) begin
                r_bar_count <= r_bar_count + CNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_code <= n_code;
            r_out_flag <= w_warm;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - CODE_W){1'b0}}, r_out_code};
    assign o_m_axis_tuser  = r_out_flag;

endmodule

@@ hw/rtl/mhd_checker.sv @@
// port-level checks of the modified hikkake detector, bound to the top level
module mhd_checker
    import mhd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  o_m_axis_tuser
);

    logic signed [CODE_W-1:0] w_code;
    assign w_code = o_m_axis_tdata[CODE_W-1:0];

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a code is only reported once warm-up is over
    a_warmup_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (w_code == CODE_NONE))
        else $error("pattern code during warm-up");

    // only the five defined codes appear
    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_code == CODE_NONE || w_code == CODE_BULL_SETUP ||
                             w_code == CODE_BEAR_SETUP || w_code == CODE_BULL_CONF ||
                             w_code == CODE_BEAR_CONF))
        else $error("undefined pattern code");

    // input side only stalls when a result is held up downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without output back-pressure");

    // a held result keeps its item
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind modified_hikkake_detector mhd_checker u_mhd_checker (.*);
